### rtl/sbpr_pkg.sv
// ----------------------------------------------------------------------------
// sbpr_pkg
// shared types and constants of the six button pad reader
// ----------------------------------------------------------------------------
package sbpr_pkg;

  localparam int unsigned PinW     = 6;
  localparam int unsigned ButtonW  = 13;
  localparam int unsigned SettleW  = 8;
  localparam int unsigned RecoverW = 12;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [SettleW-1:0]  SettleReset  = 8'd14;
  localparam logic [RecoverW-1:0] RecoverReset = 12'd2000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETTLE  = 1'b0,
    CFG_RECOVER = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_HI1  = 4'd1,
    PH_LO1  = 4'd2,
    PH_HI2  = 4'd3,
    PH_LO2  = 4'd4,
    PH_HI3  = 4'd5,
    PH_LO3  = 4'd6,
    PH_HI4  = 4'd7,
    PH_REC  = 4'd8
  } phase_t;

  typedef struct packed {
    logic               select_level;
    logic               busy;
    logic               done;
    logic [ButtonW-1:0] buttons;
    logic               six_button;
    logic               menu;
  } result_t;

endpackage

### rtl/sbpr_in_if.sv
// ----------------------------------------------------------------------------
// sbpr_in_if
// tick channel: start request and raw pin levels
// ----------------------------------------------------------------------------
interface sbpr_in_if;
  import sbpr_pkg::*;

  logic            valid;
  logic            ready;
  logic            start_read;
  logic [PinW-1:0] pin_levels;

  modport source (output valid, output start_read, output pin_levels, input ready);
  modport sink   (input valid, input start_read, input pin_levels, output ready);
endinterface

### rtl/sbpr_out_if.sv
// ----------------------------------------------------------------------------
// sbpr_out_if
// result channel: select level, status and button word
// ----------------------------------------------------------------------------
interface sbpr_out_if;
  import sbpr_pkg::*;

  logic               valid;
  logic               ready;
  logic               select_level;
  logic               busy_res;
  logic               done_res;
  logic [ButtonW-1:0] buttons;
  logic               six_button;
  logic               menu;

  modport source (output valid, output select_level, output busy_res, output done_res,
                  output buttons, output six_button, output menu, input ready);
  modport sink   (input valid, input select_level, input busy_res, input done_res,
                  input buttons, input six_button, input menu, output ready);
endinterface

### rtl/sbpr_seq.sv
// ----------------------------------------------------------------------------
// sbpr_seq
// read sequencer: advances one step per tick and forms the result of it
// ----------------------------------------------------------------------------
module sbpr_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          start_read,
  input  logic [sbpr_pkg::PinW-1:0]     pin_levels,
  input  logic [sbpr_pkg::SettleW-1:0]  settle_ticks,
  input  logic [sbpr_pkg::RecoverW-1:0] recovery_ticks,
  output sbpr_pkg::result_t             result_next
);
  import sbpr_pkg::*;

  phase_t              phase, phase_next;
  logic [RecoverW-1:0] wait_count, wait_count_next;
  logic [ButtonW-1:0]  button_word, button_word_next;
  logic                six_flag, six_flag_next;
  logic                select_reg, select_reg_next;
  logic                done;
  logic [PinW-1:0]     pressed;
  logic [RecoverW-1:0] settle_ext;

  assign pressed    = ~pin_levels;
  assign settle_ext = {{(RecoverW-SettleW){1'b0}}, settle_ticks};

  always_comb begin
    phase_next       = phase;
    wait_count_next  = wait_count;
    button_word_next = button_word;
    six_flag_next    = six_flag;
    select_reg_next  = select_reg;
    done             = 1'b0;

    if (phase == PH_IDLE || phase > PH_REC) begin
      phase_next = PH_IDLE;
      if (start_read) begin
        button_word_next = '0;
        six_flag_next    = 1'b0;
        select_reg_next  = 1'b1;
        wait_count_next  = settle_ext;
        phase_next       = PH_HI1;
      end
    end else if (wait_count > 12'd1) begin
      wait_count_next = wait_count - 12'd1;
    end else begin
      case (phase)
        PH_HI1: begin
          button_word_next = {{(ButtonW-PinW){1'b0}}, pressed};
          select_reg_next  = 1'b0;
          wait_count_next  = settle_ext;
          phase_next       = PH_LO1;
        end
        PH_LO1: begin
          if (pressed[3:2] != 2'b11) begin
            phase_next      = PH_IDLE;
            wait_count_next = '0;
            done            = 1'b1;
          end else begin
            button_word_next[7:6] = pressed[5:4];
            select_reg_next       = 1'b1;
            wait_count_next       = settle_ext;
            phase_next            = PH_HI2;
          end
        end
        PH_HI2: begin
          select_reg_next = 1'b0;
          wait_count_next = settle_ext;
          phase_next      = PH_LO2;
        end
        PH_LO2: begin
          if (pressed[3:0] == 4'hF) begin
            select_reg_next = 1'b1;
            wait_count_next = settle_ext;
            phase_next      = PH_HI3;
          end else begin
            phase_next      = PH_IDLE;
            wait_count_next = '0;
            done            = 1'b1;
          end
        end
        PH_HI3: begin
          button_word_next[11:8] = button_word[11:8] | pressed[3:0];
          select_reg_next        = 1'b0;
          wait_count_next        = settle_ext;
          phase_next             = PH_LO3;
        end
        PH_LO3: begin
          button_word_next[12] = button_word[12] | pressed[0];
          select_reg_next      = 1'b1;
          wait_count_next      = settle_ext;
          phase_next           = PH_HI4;
        end
        PH_HI4: begin
          select_reg_next = 1'b0;
          six_flag_next   = 1'b1;
          if (recovery_ticks == '0) begin
            phase_next      = PH_IDLE;
            wait_count_next = '0;
            done            = 1'b1;
          end else begin
            wait_count_next = recovery_ticks;
            phase_next      = PH_REC;
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          wait_count_next = '0;
          done            = 1'b1;
        end
      endcase
    end

    result_next.select_level = select_reg_next;
    result_next.busy         = (phase_next != PH_IDLE);
    result_next.done         = done;
    result_next.buttons      = button_word_next;
    result_next.six_button   = six_flag_next;
    result_next.menu         = (button_word_next[0] & button_word_next[7]) |
                               button_word_next[12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      wait_count  <= '0;
      button_word <= '0;
      six_flag    <= 1'b0;
      select_reg  <= 1'b1;
    end else if (step) begin
      phase       <= phase_next;
      wait_count  <= wait_count_next;
      button_word <= button_word_next;
      six_flag    <= six_flag_next;
      select_reg  <= select_reg_next;
    end
  end

endmodule

### rtl/six_button_pad_reader.sv
// ----------------------------------------------------------------------------
// six_button_pad_reader
// tick driven reader for a select multiplexed six button game pad
// ----------------------------------------------------------------------------
// Each input item is one timer tick with the raw active-low pin levels, and
// each accepted item yields exactly one result item with the select level to
// drive, busy, a done pulse, the button word, the six-button flag and the
// menu combination. One item is taken per clock: the sequencer step is
// combinational into the result register, refilled in the same cycle it
// is taken, so the rate is set only by the sink's ready. The user writes
// settle_ticks and recovery_ticks while no read is in progress (unenforced).
module six_button_pad_reader (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sbpr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sbpr_pkg::CfgDataW-1:0]  cfg_data,
  sbpr_in_if.sink                        tick,
  sbpr_out_if.source                     res
);
  import sbpr_pkg::*;

  logic [SettleW-1:0]  settle_ticks;
  logic [RecoverW-1:0] recovery_ticks;
  logic                step;
  logic                res_valid;
  result_t             result_next;
  result_t             result;

  assign tick.ready = !res_valid || res.ready;
  assign step       = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks   <= SettleReset;
      recovery_ticks <= RecoverReset;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SETTLE:  settle_ticks   <= cfg_data[SettleW-1:0];
        CFG_RECOVER: recovery_ticks <= cfg_data[RecoverW-1:0];
        default: ;
      endcase
    end
  end

  sbpr_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .start_read     (tick.start_read),
    .pin_levels     (tick.pin_levels),
    .settle_ticks   (settle_ticks),
    .recovery_ticks (recovery_ticks),
    .result_next    (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

  assign res.valid        = res_valid;
  assign res.select_level = result.select_level;
  assign res.busy_res     = result.busy;
  assign res.done_res     = result.done;
  assign res.buttons      = result.buttons;
  assign res.six_button   = result.six_button;
  assign res.menu         = result.menu;

endmodule
